>>> hw/rtl/cuws_pkg.sv
// ----------------------------------------------------------------------------
// cuws_pkg
// Shared types and constants for the CPU utilisation window statistics block.
// ----------------------------------------------------------------------------
package cuws_pkg;

    localparam int NFIELD  = 8;
    localparam int NCAT    = 7;
    localparam int CNT_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int RATE_W  = 14;
    localparam int CAT_W   = 3;
    localparam int FIELD_W = 3;

    localparam logic [RATE_W-1:0] RATE_RESET = 14'd100;
    localparam logic [9:0]        TICK_SCALE = 10'd1000;
    localparam logic [FRAC_W-1:0] FRAC_MAX   = 16'hFFFF;
    localparam logic [FRAC_W-1:0] FRAC_ZERO  = 16'h0000;
    localparam logic [CAT_W-1:0]  CAT_LAST   = 3'd6;
    localparam logic [FIELD_W-1:0] FIELD_LAST = 3'd7;
    localparam logic [FIELD_W-1:0] FIELD_TIME = 3'd0;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_SUM_RD    = 10'b00_0000_0010,
        S_SUM_WR    = 10'b00_0000_0100,
        S_FRAC_GO   = 10'b00_0000_1000,
        S_FRAC_WAIT = 10'b00_0001_0000,
        S_ADV       = 10'b00_0010_0000,
        S_STAT_GO   = 10'b00_0100_0000,
        S_SCAN      = 10'b00_1000_0000,
        S_STAT_WAIT = 10'b01_0000_0000,
        S_OUT       = 10'b10_0000_0000
    } t_state;

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_CHK  = 3'b010,
        D_ITER = 3'b100
    } t_div_state;

    typedef struct packed {
        logic               load_snap;
        logic               sum_rd;
        logic               sum_wr;
        logic               frac_go;
        logic               frac_wr;
        logic               advance;
        logic               stat_go;
        logic               scan_step;
        logic               out_load;
        logic [FIELD_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic have_prev;
        logic div_busy;
        logic scan_last;
        logic cmp_vld;
    } t_status;

endpackage

>>> hw/rtl/cpu_utilization_window_stats.sv
// ----------------------------------------------------------------------------
// cpu_utilization_window_stats
// Per-category CPU utilisation over a sliding window of snapshot intervals.
// ----------------------------------------------------------------------------
// Each input beat is a snapshot of a millisecond timestamp and seven
// cumulative tick counters. The first snapshot after reset only primes the
// block; each later one yields seven result beats (user, nice, kernel, idle,
// iowait, irq, softirq, run_end on the last) carrying the newest, minimum,
// maximum and average fraction in Q0.16 over the last WINDOW intervals.
// One snapshot is worked on at a time and o_stall stays high until its last
// result beat is taken. The shared restoring divider works each fraction as
// product, range check and 16 quotient bits, and the min/max scan reads one
// ring entry a cycle from the fraction RAM, overlapped with the average
// division.
// The tick rate may be written at any idle moment through i_cfg_wr_en.
// ----------------------------------------------------------------------------
module cpu_utilization_window_stats
    import cuws_pkg::*;
#(
    parameter int WINDOW = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [RATE_W-1:0] i_cfg_wr_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CNT_W-1:0]  i_time_ms,
    input  logic [CNT_W-1:0]  i_user_count,
    input  logic [CNT_W-1:0]  i_nice_count,
    input  logic [CNT_W-1:0]  i_kernel_count,
    input  logic [CNT_W-1:0]  i_idle_count,
    input  logic [CNT_W-1:0]  i_io_wait_count,
    input  logic [CNT_W-1:0]  i_hard_irq_count,
    input  logic [CNT_W-1:0]  i_soft_irq_count,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CAT_W-1:0]  o_category,
    output logic [FRAC_W-1:0] o_newest_fraction,
    output logic [FRAC_W-1:0] o_min_fraction,
    output logic [FRAC_W-1:0] o_max_fraction,
    output logic [FRAC_W-1:0] o_avg_fraction,
    output logic              o_run_end
);

    t_cmd                         cmd;
    t_status                      status;
    logic [NFIELD-1:0][CNT_W-1:0] snap;

    // field 0 is time, then the categories in output order
    assign snap = {i_soft_irq_count, i_hard_irq_count, i_io_wait_count, i_idle_count,
                   i_kernel_count, i_nice_count, i_user_count, i_time_ms};

    cuws_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    cuws_dp #(.WINDOW(WINDOW)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_snap            (snap),
        .o_category        (o_category),
        .o_newest_fraction (o_newest_fraction),
        .o_min_fraction    (o_min_fraction),
        .o_max_fraction    (o_max_fraction),
        .o_avg_fraction    (o_avg_fraction),
        .o_run_end         (o_run_end)
    );

endmodule

>>> hw/rtl/cuws_ram.sv
// ----------------------------------------------------------------------------
// cuws_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cuws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/cuws_div.sv
// ----------------------------------------------------------------------------
// cuws_div
// Rate fraction unit: ticks*1000 / (dt*rate) in Q0.16, one quotient bit per
// cycle, saturating, zero on a zero denominator.
// ----------------------------------------------------------------------------
module cuws_div
    import cuws_pkg::*;
#(
    parameter int SUM_W = 36
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_ticks,
    input  logic [SUM_W-1:0]  i_dt,
    input  logic [RATE_W-1:0] i_rate,
    output logic              o_busy,
    output logic [FRAC_W-1:0] o_q
);

    localparam int DEN_W = SUM_W + RATE_W;
    localparam int CNT_W_D = $clog2(FRAC_W);

    t_div_state          r_state;
    logic [DEN_W-1:0]    r_num;
    logic [DEN_W-1:0]    r_den;
    logic [DEN_W-1:0]    r_rem;
    logic [FRAC_W-1:0]   r_q;
    logic [CNT_W_D-1:0]  r_cnt;
    logic [DEN_W:0]      shifted;
    logic                take;

    assign shifted = {r_rem, 1'b0};
    assign take    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_num   <= DEN_W'(i_ticks) * DEN_W'(TICK_SCALE);
                        r_den   <= DEN_W'(i_dt) * DEN_W'(i_rate);
                        r_state <= D_CHK;
                    end
                end
                D_CHK: begin
                    if (r_den == '0) begin
                        r_q     <= FRAC_ZERO;
                        r_state <= D_IDLE;
                    end else if (r_num >= r_den) begin
                        r_q     <= FRAC_MAX;
                        r_state <= D_IDLE;
                    end else begin
                        r_rem   <= r_num;
                        r_q     <= FRAC_ZERO;
                        r_cnt   <= '0;
                        r_state <= D_ITER;
                    end
                end
                D_ITER: begin
                    r_rem <= take ? DEN_W'(shifted - {1'b0, r_den}) : DEN_W'(shifted);
                    r_q   <= {r_q[FRAC_W-2:0], take};
                    r_cnt <= r_cnt + CNT_W_D'(1);
                    if (r_cnt == CNT_W_D'(FRAC_W - 1)) begin
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != D_IDLE);
    assign o_q    = r_q;

endmodule

>>> hw/rtl/cuws_dp.sv
// ----------------------------------------------------------------------------
// cuws_dp
// Datapath: snapshot deltas, window sums, delta and fraction rings, scan
// for min/max, fraction unit and the result register.
// ----------------------------------------------------------------------------
module cuws_dp
    import cuws_pkg::*;
#(
    parameter int WINDOW = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cmd                           i_cmd,
    output t_status                        o_status,
    input  logic                           i_cfg_wr_en,
    input  logic [RATE_W-1:0]              i_cfg_wr_data,
    input  logic [NFIELD-1:0][CNT_W-1:0]   i_snap,
    output logic [CAT_W-1:0]               o_category,
    output logic [FRAC_W-1:0]              o_newest_fraction,
    output logic [FRAC_W-1:0]              o_min_fraction,
    output logic [FRAC_W-1:0]              o_max_fraction,
    output logic [FRAC_W-1:0]              o_avg_fraction,
    output logic                           o_run_end
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = CNT_W + SLOT_W;
    localparam int DEPTH  = WINDOW * NFIELD;
    localparam int ADDR_W = SLOT_W + FIELD_W;

    logic [CNT_W-1:0]   r_prev  [NFIELD];
    logic [CNT_W-1:0]   r_delta [NFIELD];
    logic [SUM_W-1:0]   r_sum   [NFIELD];
    logic [FRAC_W-1:0]  r_newest [NCAT];
    logic               r_have_prev;
    logic [SLOT_W-1:0]  r_wr_idx;
    logic [FILL_W-1:0]  r_fill;
    logic [RATE_W-1:0]  r_rate;
    logic [SLOT_W-1:0]  r_scan_idx;
    logic               r_cmp_vld;
    logic [FRAC_W-1:0]  r_min;
    logic [FRAC_W-1:0]  r_max;
    logic [CAT_W-1:0]   r_o_cat;
    logic [FRAC_W-1:0]  r_o_newest;
    logic [FRAC_W-1:0]  r_o_min;
    logic [FRAC_W-1:0]  r_o_max;
    logic [FRAC_W-1:0]  r_o_avg;
    logic               r_o_end;

    logic               full;
    logic [CNT_W-1:0]   delta_rdata;
    logic [FRAC_W-1:0]  frac_rdata;
    logic [SUM_W-1:0]   old_delta;
    logic [FIELD_W-1:0] tick_idx;
    logic [SUM_W-1:0]   div_ticks;
    logic [SUM_W-1:0]   div_dt;
    logic               div_busy;
    logic [FRAC_W-1:0]  div_q;
    logic [ADDR_W-1:0]  delta_addr;

    assign full       = (r_fill == FILL_W'(WINDOW));
    assign old_delta  = full ? SUM_W'(delta_rdata) : '0;
    assign tick_idx   = i_cmd.idx + FIELD_W'(1);
    assign delta_addr = {r_wr_idx, i_cmd.idx};

    always_comb begin
        if (i_cmd.stat_go) begin
            div_ticks = r_sum[tick_idx];
            div_dt    = r_sum[FIELD_TIME];
        end else begin
            div_ticks = SUM_W'(r_delta[tick_idx]);
            div_dt    = SUM_W'(r_delta[FIELD_TIME]);
        end
    end

    cuws_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_delta_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.sum_wr),
        .i_waddr (delta_addr),
        .i_wdata (r_delta[i_cmd.idx]),
        .i_re    (i_cmd.sum_rd),
        .i_raddr (delta_addr),
        .o_rdata (delta_rdata)
    );

    cuws_ram #(.WIDTH(FRAC_W), .DEPTH(DEPTH)) u_frac_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.frac_wr),
        .i_waddr ({r_wr_idx, i_cmd.idx}),
        .i_wdata (div_q),
        .i_re    (i_cmd.scan_step),
        .i_raddr ({r_scan_idx, i_cmd.idx}),
        .o_rdata (frac_rdata)
    );

    cuws_div #(.SUM_W(SUM_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.frac_go | i_cmd.stat_go),
        .i_ticks (div_ticks),
        .i_dt    (div_dt),
        .i_rate  (r_rate),
        .o_busy  (div_busy),
        .o_q     (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_wr_idx    <= '0;
            r_fill      <= '0;
            r_rate      <= RATE_RESET;
            r_cmp_vld   <= 1'b0;
            for (int f = 0; f < NFIELD; f++) begin
                r_sum[f] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_rate <= i_cfg_wr_data;
            end
            if (i_cmd.load_snap) begin
                r_have_prev <= 1'b1;
                for (int f = 0; f < NFIELD; f++) begin
                    r_prev[f]  <= i_snap[f];
                    r_delta[f] <= i_snap[f] - r_prev[f];
                end
            end
            if (i_cmd.sum_wr) begin
                r_sum[i_cmd.idx] <= r_sum[i_cmd.idx] - old_delta
                                    + SUM_W'(r_delta[i_cmd.idx]);
            end
            if (i_cmd.frac_wr) begin
                r_newest[i_cmd.idx] <= div_q;
            end
            if (i_cmd.advance) begin
                r_wr_idx <= (r_wr_idx == SLOT_W'(WINDOW - 1)) ? '0
                                                               : r_wr_idx + SLOT_W'(1);
                if (!full) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
            // scan pipeline: address this cycle, compare the next
            r_cmp_vld <= i_cmd.scan_step;
            if (i_cmd.stat_go) begin
                r_scan_idx <= '0;
                r_min      <= FRAC_MAX;
                r_max      <= FRAC_ZERO;
            end else begin
                if (i_cmd.scan_step) begin
                    r_scan_idx <= r_scan_idx + SLOT_W'(1);
                end
                if (r_cmp_vld) begin
                    if (frac_rdata < r_min) begin
                        r_min <= frac_rdata;
                    end
                    if (frac_rdata > r_max) begin
                        r_max <= frac_rdata;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_cat    <= i_cmd.idx;
            r_o_newest <= r_newest[i_cmd.idx];
            r_o_min    <= r_min;
            r_o_max    <= r_max;
            r_o_avg    <= div_q;
            r_o_end    <= (i_cmd.idx == CAT_LAST);
        end
    end

    assign o_status.have_prev = r_have_prev;
    assign o_status.div_busy  = div_busy;
    assign o_status.scan_last = (FILL_W'(r_scan_idx) == r_fill - FILL_W'(1));
    assign o_status.cmp_vld   = r_cmp_vld;

    assign o_category        = r_o_cat;
    assign o_newest_fraction = r_o_newest;
    assign o_min_fraction    = r_o_min;
    assign o_max_fraction    = r_o_max;
    assign o_avg_fraction    = r_o_avg;
    assign o_run_end         = r_o_end;

endmodule

>>> hw/rtl/cuws_ctrl.sv
// ----------------------------------------------------------------------------
// cuws_ctrl
// Sequencer: sum update per field, fraction per category, then per category
// a window scan with the average division and one result beat.
// ----------------------------------------------------------------------------
module cuws_ctrl
    import cuws_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state             r_state;
    t_state             n_state;
    logic [FIELD_W-1:0] r_idx;
    logic [FIELD_W-1:0] n_idx;
    logic               r_out_vld;
    logic               n_out_vld;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_out_vld = r_out_vld;
        o_cmd     = '0;
        o_cmd.idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_snap = 1'b1;
                    n_idx           = '0;
                    if (i_status.have_prev) begin
                        n_state = S_SUM_RD;
                    end
                end
            end
            S_SUM_RD: begin
                o_cmd.sum_rd = 1'b1;
                n_state      = S_SUM_WR;
            end
            S_SUM_WR: begin
                o_cmd.sum_wr = 1'b1;
                if (r_idx == FIELD_LAST) begin
                    n_idx   = '0;
                    n_state = S_FRAC_GO;
                end else begin
                    n_idx   = r_idx + FIELD_W'(1);
                    n_state = S_SUM_RD;
                end
            end
            S_FRAC_GO: begin
                o_cmd.frac_go = 1'b1;
                n_state       = S_FRAC_WAIT;
            end
            S_FRAC_WAIT: begin
                if (!i_status.div_busy) begin
                    o_cmd.frac_wr = 1'b1;
                    if (r_idx == CAT_LAST) begin
                        n_idx   = '0;
                        n_state = S_ADV;
                    end else begin
                        n_idx   = r_idx + FIELD_W'(1);
                        n_state = S_FRAC_GO;
                    end
                end
            end
            S_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = S_STAT_GO;
            end
            S_STAT_GO: begin
                o_cmd.stat_go = 1'b1;
                n_state       = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_STAT_WAIT;
                end
            end
            S_STAT_WAIT: begin
                if (!i_status.div_busy && !i_status.cmp_vld) begin
                    o_cmd.out_load = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_out_vld = 1'b0;
                    if (r_idx == CAT_LAST) begin
                        n_idx   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + FIELD_W'(1);
                        n_state = S_STAT_GO;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_vld;

endmodule

>>> hw/rtl/cuws_checker.sv
// ----------------------------------------------------------------------------
// cuws_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cuws_checker
    import cuws_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [CAT_W-1:0]  o_category,
    input logic [FRAC_W-1:0] o_newest_fraction,
    input logic [FRAC_W-1:0] o_min_fraction,
    input logic [FRAC_W-1:0] o_max_fraction,
    input logic [FRAC_W-1:0] o_avg_fraction,
    input logic              o_run_end
);

    // hold the input side while any result beat is pending
    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while a result beat is pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_category) && $stable(o_avg_fraction)
            && $stable(o_newest_fraction))
        else $error("stalled result beat changed");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_min_fraction <= o_newest_fraction
            && o_newest_fraction <= o_max_fraction)
        else $error("newest fraction outside window min/max");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_run_end == (o_category == CAT_LAST))
        else $error("run_end not on last category");

endmodule

bind cpu_utilization_window_stats cuws_checker u_cuws_checker (.*);
